>>> rtl/cmwc_pkg.sv
// cmwc_pkg: word types, constants and the xorshift step for the
// lag-16 complementary multiply-with-carry generator
// no dependencies
package cmwc_pkg;

	localparam int LAG_DEPTH = 16;
	localparam int IDX_W     = $clog2(LAG_DEPTH);

	localparam logic [31:0]      CMWC_MULT       = 32'd487198574;
	localparam logic [31:0]      CMWC_CARRY_INIT = 32'd362436;
	localparam logic [31:0]      CMWC_COMPLEMENT = 32'hFFFF_FFFE;
	localparam logic [IDX_W-1:0] IDX_RESEED      = IDX_W'(15);
	localparam logic [63:0]      FALLBACK_RESET  = 64'd1;

	localparam logic OP_DRAW   = 1'b0;
	localparam logic OP_RESEED = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [63:0] seed_value;
	} in_word_t;

	typedef struct packed {
		logic [31:0] random_word;
		logic        is_draw;
	} out_word_t;

	// one 13/17/5 xorshift step
	function automatic logic [31:0] xorshift_step(input logic [31:0] w);
		logic [31:0] a;
		logic [31:0] b;
		a = w ^ (w << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

>>> rtl/cmwc_random_generator_unit.sv
// cmwc_random_generator_unit: lag-16 cmwc generator, draw or reseed per word
// depends on cmwc_pkg (types, constants, xorshift step)
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   in_word (operation, seed_value)
// out       output     out_valid / out_stall out_word (random_word, is_draw)
// cfg       input      cfg_wr_en             cfg_wr_data (fallback seed, 64 bits)
//
// a draw: lag word read and multiply-add, then carry fix-up and write-back
// a reseed: 16 xorshift steps through the one shift unit,
// one table write per cycle, then the fix of word 15 and the result
// one word is in work at a time; a new word is taken while the result waits
// a stalled output holds the sequencer in its last state
// reset loads carry 362436, index 15, zero table, fallback seed 1
module cmwc_random_generator_unit
	import cmwc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        cfg_wr_en,
	input  logic [63:0] cfg_wr_data
);

	// sequencer codes
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_MUL     = 3'd1;
	localparam logic [2:0] ST_FIX     = 3'd2;
	localparam logic [2:0] ST_SEED    = 3'd3;
	localparam logic [2:0] ST_SEEDEND = 3'd4;

	logic [2:0]       state_q;
	logic [31:0]      table_q [LAG_DEPTH];
	logic [31:0]      carry_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cnt_q;
	logic [63:0]      fallback_q;
	logic [63:0]      seed_q;
	logic [31:0]      w_q;
	logic [63:0]      prod_q;
	logic             out_valid_q;
	out_word_t        out_q;

	logic             in_acc;
	logic             out_free;
	logic [63:0]      seed_pick;
	logic [63:0]      prod_c;
	logic [31:0]      carry_new;
	logic [31:0]      xsum;
	logic             wrap;
	logic [31:0]      x_fix;
	logic [31:0]      carry_fix;
	logic [31:0]      draw_word;
	logic [31:0]      w_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	// output register can take a result this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// zero seed falls back to the config register
	assign seed_pick = (in_word.seed_value == 64'd0) ? fallback_q : in_word.seed_value;

	// multiply-add of the lag word, registered before the fix-up
	assign prod_c = ({32'd0, CMWC_MULT} * {32'd0, table_q[idx_q]}) + {32'd0, carry_q};

	// carry-overflow fix-up and complement
	assign carry_new = prod_q[63:32];
	assign xsum      = prod_q[31:0] + carry_new;
	assign wrap      = (xsum < carry_new);
	assign x_fix     = xsum + {31'd0, wrap};
	assign carry_fix = carry_new + {31'd0, wrap};
	assign draw_word = CMWC_COMPLEMENT - x_fix;

	// shared shift unit for the table fill
	assign w_next = xorshift_step(w_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			carry_q     <= CMWC_CARRY_INIT;
			idx_q       <= IDX_RESEED;
			cnt_q       <= '0;
			fallback_q  <= FALLBACK_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LAG_DEPTH; i++) begin
				table_q[i] <= 32'd0;
			end
		end else begin
			if (cfg_wr_en) begin
				fallback_q <= cfg_wr_data;
			end
			// result register: load on a finished word, clear once taken
			if ((state_q inside {ST_FIX, ST_SEEDEND}) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_word.operation == OP_RESEED) begin
							carry_q <= CMWC_CARRY_INIT;
							idx_q   <= IDX_RESEED;
							cnt_q   <= '0;
							state_q <= ST_SEED;
						end else begin
							// index advances before the read
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (out_free) begin
						table_q[idx_q] <= draw_word;
						carry_q        <= carry_fix;
						state_q        <= ST_IDLE;
					end
				end
				ST_SEED: begin
					table_q[cnt_q] <= w_next;
					cnt_q          <= cnt_q + IDX_W'(1);
					if (cnt_q == IDX_W'(LAG_DEPTH - 1)) begin
						state_q <= ST_SEEDEND;
					end
				end
				ST_SEEDEND: begin
					if (out_free) begin
						// last word folds both seed halves
						table_q[IDX_RESEED] <= seed_q[31:0] ^ seed_q[63:32];
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			seed_q <= seed_pick;
			w_q    <= seed_pick[31:0];
		end else if (state_q == ST_SEED) begin
			w_q <= w_next;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_c;
		end
		if (state_q == ST_FIX && out_free) begin
			out_q <= '{random_word: draw_word, is_draw: 1'b1};
		end else if (state_q == ST_SEEDEND && out_free) begin
			out_q <= '{random_word: 32'd0, is_draw: 1'b0};
		end
	end

	// an accepted draw goes straight to the multiply step
	a_draw_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_word.operation == OP_DRAW) |=> state_q == ST_MUL)
		else $error("draw did not enter multiply step");

	// fix-up only follows the multiply or a stalled fix-up
	a_fix_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |-> ($past(state_q) == ST_MUL || $past(state_q) == ST_FIX))
		else $error("fix-up without multiply");

	// a reseed result leaves carry and index at their reseed values
	a_reseed_state: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && !out_q.is_draw) |->
		(carry_q == CMWC_CARRY_INIT && idx_q == IDX_RESEED))
		else $error("reseed left wrong carry or index");

	// table fill ends after the last entry
	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEEDEND && $past(state_q) == ST_SEED) |->
		$past(cnt_q) == IDX_W'(LAG_DEPTH - 1))
		else $error("table fill ended early");

endmodule

>>> tb/cmwc_random_generator_unit_test.sv
`timescale 1ns / 100ps
// cmwc_random_generator_unit_test: self-checking bench for the lag-16 cmwc generator
// predicts every result word in its own model of the lag table, carry and index
// depends on cmwc_pkg and cmwc_random_generator_unit
module cmwc_random_generator_unit_test;
	import cmwc_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake and no config write
	localparam int SETTLE_CYCLES  = 25;    // longer than one reseed
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_word;
	logic        cfg_wr_en;
	logic [63:0] cfg_wr_data;

	// generator model state
	logic [31:0]      lag_words [LAG_DEPTH];
	logic [31:0]      carry_model;
	logic [IDX_W-1:0] lag_pos;
	logic [63:0]      fallback_model;

	// predicted results in arrival order
	out_word_t pending_results [$];

	int  fail_count;
	int  quiet_cycles;
	bit  in_gaps_on;
	bit  out_gaps_on;
	bit  hold_request;

	cmwc_random_generator_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// advance the model by one accepted word and return the result it should give
	function automatic out_word_t predict_word(input in_word_t w);
		logic [63:0] seed;
		logic [63:0] prod;
		logic [31:0] r;
		logic [31:0] x;
		out_word_t   res;
		if (w.operation == OP_RESEED) begin
			carry_model = CMWC_CARRY_INIT;
			lag_pos = IDX_RESEED;
			seed = w.seed_value;
			// zero seed falls back on the register, which may itself be zero
			if (seed == 64'd0)
				seed = fallback_model;
			r = seed[31:0];
			for (int k = 0; k < LAG_DEPTH; k++) begin
				r = r ^ (r << 13);
				r = r ^ (r >> 17);
				r = r ^ (r << 5);
				lag_words[k] = r;
			end
			lag_words[IDX_RESEED] = seed[31:0] ^ seed[63:32];
			res.random_word = 32'd0;
			res.is_draw = 1'b0;
		end else begin
			lag_pos = lag_pos + 1'b1;
			prod = {32'd0, CMWC_MULT} * {32'd0, lag_words[lag_pos]} + {32'd0, carry_model};
			carry_model = prod[63:32];
			x = prod[31:0] + carry_model;
			// carry overflow fix-up
			if (x < carry_model) begin
				x = x + 1'b1;
				carry_model = carry_model + 1'b1;
			end
			x = CMWC_COMPLEMENT - x;
			lag_words[lag_pos] = x;
			res.random_word = x;
			res.is_draw = 1'b1;
		end
		return res;
	endfunction

	// input side monitor: config writes and accepted words feed the model
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				fallback_model = cfg_wr_data;
			if (in_valid && !in_stall)
				pending_results.push_back(predict_word(in_word));
		end
	end

	// output side checker: oldest prediction against every accepted result
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word %h/%b with nothing expected",
					out_word.random_word, out_word.is_draw);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_word.random_word !== want.random_word) begin
					$error("random_word: expected %h, actual %h",
						want.random_word, out_word.random_word);
					fail_count++;
				end
				if (out_word.is_draw !== want.is_draw) begin
					$error("is_draw: expected %b, actual %b", want.is_draw, out_word.is_draw);
					fail_count++;
				end
			end
		end
	end

	// receiver: random stall bursts, or one long hold-off on request
	always begin
		@(posedge clk);
		if (hold_request) begin
			hold_request = 1'b0;
			out_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			out_stall <= 1'b0;
		end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog: any handshake or config write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL cmwc_random_generator_unit");
				$finish;
			end
		end
	end

	// offer one word, with an optional idle burst ahead of it, and wait until taken
	task automatic send_word(input logic op, input logic [63:0] seed);
		in_word_t w;
		w.operation = op;
		w.seed_value = seed;
		if (in_gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// mostly draws, some reseeds, a share of them with a zero seed
	task automatic send_random_word();
		logic        op;
		logic [63:0] seed;
		op = ($urandom_range(0, 9) == 0) ? OP_RESEED : OP_DRAW;
		seed = {$urandom, $urandom};
		if ($urandom_range(0, 7) == 0)
			seed = 64'd0;
		send_word(op, seed);
	endtask

	// drop valid, let every predicted result arrive, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// fallback register is only written with the block idle
	task automatic write_fallback(input logic [63:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// draws on the reset state: all-zero table, carry 362436
	task automatic test_draw_before_reseed();
		send_word(OP_DRAW, '1);
		send_word(OP_DRAW, 64'd0);
		send_word(OP_DRAW, {$urandom, $urandom});
	endtask

	// seed extremes, including zero with the reset fallback of one
	task automatic test_directed_seeds();
		send_word(OP_RESEED, 64'd0);
		send_word(OP_DRAW, 64'd0);
		send_word(OP_DRAW, '1);
		send_word(OP_RESEED, '1);
		send_word(OP_DRAW, 64'd0);
		send_word(OP_DRAW, '1);
		// zero low half: xorshift chain stays zero, only word 15 is set
		send_word(OP_RESEED, 64'hFFFF_FFFF_0000_0000);
		send_word(OP_DRAW, 64'd0);
		send_word(OP_RESEED, 64'h0000_0000_FFFF_FFFF);
		send_word(OP_DRAW, 64'd0);
		send_word(OP_RESEED, 64'h8000_0000_0000_0001);
		send_word(OP_DRAW, 64'd0);
	endtask

	// zero fallback turns a zero seed into an all-zero table
	task automatic test_zero_fallback();
		write_fallback(64'd0);
		send_word(OP_RESEED, 64'd0);
		send_word(OP_DRAW, 64'd0);
		send_word(OP_DRAW, 64'd0);
		write_fallback('1);
		send_word(OP_RESEED, 64'd0);
		send_word(OP_DRAW, 64'd0);
	endtask

	// random traffic in phases, each under a different fallback setting
	task automatic test_random_traffic();
		logic [63:0] settings [4];
		settings[0] = {$urandom, $urandom};
		settings[1] = FALLBACK_RESET;
		settings[2] = '1;
		settings[3] = 64'd0;
		for (int p = 0; p < 4; p++) begin
			write_fallback(settings[p]);
			repeat (250) send_random_word();
		end
		write_fallback({$urandom, $urandom});
	endtask

	// receiver holds off long enough that the block fills and stalls its input
	task automatic test_backpressure();
		hold_request = 1'b1;
		repeat (40) send_random_word();
	endtask

	// closing stretch at full rate on both sides
	task automatic test_steady_stream();
		wait_idle();
		in_gaps_on = 1'b0;
		out_gaps_on = 1'b0;
		repeat (200) send_random_word();
	endtask

	initial begin
		fail_count = 0;
		quiet_cycles = 0;
		in_gaps_on = 1'b1;
		out_gaps_on = 1'b1;
		hold_request = 1'b0;
		// model matches the block's reset state
		for (int k = 0; k < LAG_DEPTH; k++)
			lag_words[k] = 32'd0;
		carry_model = CMWC_CARRY_INIT;
		lag_pos = IDX_RESEED;
		fallback_model = FALLBACK_RESET;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		out_stall <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_draw_before_reseed();
		test_directed_seeds();
		test_zero_fallback();
		test_random_traffic();
		test_backpressure();
		test_steady_stream();

		// drain everything still in flight
		wait_idle();
		if (pending_results.size() != 0) begin
			$error("%0d expected result words never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("PASS cmwc_random_generator_unit");
		else
			$display("FAIL cmwc_random_generator_unit");
		$finish;
	end

endmodule

>>> files.f
rtl/cmwc_pkg.sv
rtl/cmwc_random_generator_unit.sv
tb/cmwc_random_generator_unit_test.sv
